>>> rtl/core/rke_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rke_pkg
// Shared types and constants for the rotary knob event decoder.
// ----------------------------------------------------------------------------
package rke_pkg;

    localparam int unsigned TIME_W       = 32;
    localparam int unsigned EVENT_W      = 3;
    localparam int unsigned IN_TDATA_W   = 40;
    localparam int unsigned OUT_TDATA_W  = 8;
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;

    localparam logic [TIME_W-1:0] LONG_PRESS_RESET   = 32'd800;
    localparam logic [TIME_W-1:0] DOUBLE_CLICK_RESET = 32'd300;

    localparam logic LEVEL_LOW  = 1'b0;
    localparam logic LEVEL_HIGH = 1'b1;

    typedef enum logic [0:0] {
        REG_LONG_PRESS   = 1'b0,
        REG_DOUBLE_CLICK = 1'b1
    } reg_index_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_RIGHT  = 3'd1,
        EV_LEFT   = 3'd2,
        EV_SHORT  = 3'd3,
        EV_LONG   = 3'd4,
        EV_DOUBLE = 3'd5
    } event_t;

    typedef struct packed {
        logic              allow_double;
        logic [TIME_W-1:0] now_ms;
        logic              switch_level;
        logic              data_level;
        logic              clk_level;
    } poll_t;

    typedef struct packed {
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] double_click_ms;
    } cfg_t;

endpackage

>>> rtl/core/rotary_knob_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_knob_event_decoder
// Decodes encoder rotation and push-switch presses into one event per poll.
//
//   Channel  Dir  Handshake           Payload
//   s_       in   s_tvalid/s_tready   poll: levels, now_ms, allow_double
//   m_       out  m_tvalid/m_tready   event_code
//   APB      in   psel/penable/pready long_press_ms, double_click_ms
//
// One poll per cycle while m_tready does not stall; a request passes the input
// register, then is classified into the result register.
// Knob and button state update in the classify cycle, so polls chain back
// to back. aresetn is synchronous and clears state and the valid bits of both registers.
// A stalled m_tready holds the result and backs up into s_tready.
// ----------------------------------------------------------------------------
module rotary_knob_event_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] clk_level, [1] data_level, [2] switch_level, [34:3] now_ms,
    // [35] allow_double, [39:36] zero
    input  logic [rke_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] event_code, [7:3] zero
    output logic [rke_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rke_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rke_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rke_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    rke_pkg::cfg_t   cfg;
    rke_pkg::poll_t  s_poll;
    rke_pkg::poll_t  q_poll;
    logic            q_valid;
    logic            q_ready;
    rke_pkg::event_t res_event;

    assign s_poll = rke_pkg::poll_t'(s_tdata[$bits(rke_pkg::poll_t)-1:0]);

    rke_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rke_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_poll   (s_poll),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_poll  (q_poll)
    );

    rke_classifier u_cls (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_poll   (q_poll),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_event (res_event)
    );

    assign m_tdata = {{(rke_pkg::OUT_TDATA_W - rke_pkg::EVENT_W){1'b0}}, res_event};

endmodule

>>> rtl/core/rke_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rke_cfg_regs
// APB register file holding the long-press and double-click thresholds.
// ----------------------------------------------------------------------------
module rke_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rke_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rke_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rke_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output rke_pkg::cfg_t                    cfg
);

    rke_pkg::cfg_t      cfg_reg;
    rke_pkg::reg_index_t sel;
    logic               wr_en;

    assign pready = 1'b1;
    assign sel    = rke_pkg::reg_index_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms   <= rke_pkg::LONG_PRESS_RESET;
            cfg_reg.double_click_ms <= rke_pkg::DOUBLE_CLICK_RESET;
        end else if (wr_en) begin
            unique case (sel)
                rke_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ms   <= pwdata;
                rke_pkg::REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            rke_pkg::REG_LONG_PRESS:   prdata = cfg_reg.long_press_ms;
            rke_pkg::REG_DOUBLE_CLICK: prdata = cfg_reg.double_click_ms;
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/rke_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rke_in_stage
// Input register: captures one poll request and holds it until the
// classifier takes it.
// ----------------------------------------------------------------------------
module rke_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rke_pkg::poll_t in_poll,
    output logic          out_valid,
    input  logic          out_ready,
    output rke_pkg::poll_t out_poll
);

    logic          valid_reg;
    rke_pkg::poll_t poll_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            poll_reg <= in_poll;
        end
    end

    assign out_valid = valid_reg;
    assign out_poll  = poll_reg;

endmodule

>>> rtl/core/rke_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rke_classifier
// Knob and button state, rotation and press classification, and the
// result register.
// ----------------------------------------------------------------------------
module rke_classifier (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rke_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rke_pkg::poll_t        in_poll,
    output logic                  res_valid,
    input  logic                  res_ready,
    output rke_pkg::event_t       res_event
);

    logic                          prev_clk_reg,  prev_clk_next;
    logic                          held_reg,      held_next;
    logic [rke_pkg::TIME_W-1:0]    press_start_reg, press_start_next;
    logic                          awaiting_reg,  awaiting_next;
    logic [rke_pkg::TIME_W-1:0]    first_click_reg, first_click_next;
    logic                          valid_reg;
    rke_pkg::event_t               event_reg,     event_next;

    logic                          take;
    logic                          rotate;
    logic                          pressed;
    logic                          release_seen;
    logic [rke_pkg::TIME_W-1:0]    held_time;
    logic [rke_pkg::TIME_W-1:0]    gap_time;
    logic                          is_long;
    logic                          in_window;

    assign in_ready = !valid_reg || res_ready;
    assign take     = in_valid && in_ready;

    assign rotate       = (in_poll.clk_level == rke_pkg::LEVEL_LOW) &&
                          (prev_clk_reg != rke_pkg::LEVEL_LOW);
    assign pressed      = (in_poll.switch_level == rke_pkg::LEVEL_LOW);
    assign release_seen = !pressed && held_reg;
    assign held_time    = in_poll.now_ms - press_start_reg;
    assign gap_time     = in_poll.now_ms - first_click_reg;
    assign is_long      = (held_time >= cfg.long_press_ms);
    assign in_window    = (gap_time <= cfg.double_click_ms);

    always_comb begin
        prev_clk_next    = in_poll.clk_level;
        held_next        = held_reg;
        press_start_next = press_start_reg;
        awaiting_next    = awaiting_reg;
        first_click_next = first_click_reg;
        event_next       = rke_pkg::EV_NONE;
        if (rotate) begin
            event_next = in_poll.data_level ? rke_pkg::EV_RIGHT : rke_pkg::EV_LEFT;
        end else if (release_seen) begin
            held_next = 1'b0;
            priority if (is_long) begin
                awaiting_next = 1'b0;
                event_next    = rke_pkg::EV_LONG;
            end else if (!in_poll.allow_double) begin
                awaiting_next = 1'b0;
                event_next    = rke_pkg::EV_SHORT;
            end else if (awaiting_reg && in_window) begin
                awaiting_next = 1'b0;
                event_next    = rke_pkg::EV_DOUBLE;
            end else begin
                awaiting_next    = 1'b1;
                first_click_next = in_poll.now_ms;
            end
        end else begin
            if (pressed && !held_reg) begin
                held_next        = 1'b1;
                press_start_next = in_poll.now_ms;
            end
            if (awaiting_reg && !in_window) begin
                awaiting_next = 1'b0;
                event_next    = rke_pkg::EV_SHORT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_clk_reg    <= rke_pkg::LEVEL_HIGH;
            held_reg        <= 1'b0;
            press_start_reg <= '0;
            awaiting_reg    <= 1'b0;
            first_click_reg <= '0;
            valid_reg       <= 1'b0;
        end else begin
            if (take) begin
                prev_clk_reg    <= prev_clk_next;
                held_reg        <= held_next;
                press_start_reg <= press_start_next;
                awaiting_reg    <= awaiting_next;
                first_click_reg <= first_click_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            event_reg <= event_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_event = event_reg;

endmodule

>>> rtl/core/rke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rke_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rke_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rke_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= rke_pkg::EV_DOUBLE) && (m_tdata[7:3] == 5'd0))
        else $error("event code out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rotary_knob_event_decoder rke_checker u_rke_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/tb_rotary_knob_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_knob_event_decoder
// Self-checking bench for the rotary knob event decoder. Polls of knob
// levels and timestamps go in on s_, one event per poll comes back on m_.
// A scoreboard tracks encoder and button state to predict each event.
// Random stalls and gaps are applied on both streams, and the APB timing
// registers are swept through their extremes.
// ----------------------------------------------------------------------------
module tb_rotary_knob_event_decoder;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    // [0] clk_level, [1] data_level, [2] switch_level, [34:3] now_ms,
    // [35] allow_double, [39:36] zero
    logic [rke_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // [2:0] event_code, [7:3] zero
    logic [rke_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rke_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [rke_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [rke_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;

    rotary_knob_event_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Scoreboard copy of the decoder state and timing registers
    logic [rke_pkg::TIME_W-1:0] cfg_long;
    logic [rke_pkg::TIME_W-1:0] cfg_double;
    logic                       knob_prev_clk;
    logic                       btn_held;
    logic [rke_pkg::TIME_W-1:0] btn_start;
    logic                       click_pending;
    logic [rke_pkg::TIME_W-1:0] click_time;

    rke_pkg::event_t            pending_events[$];
    int                         error_count;
    int                         poll_count;
    bit                         src_idle_en;
    bit                         sink_stall_en;

    // Stimulus-side knob model
    logic [rke_pkg::TIME_W-1:0] stim_ms;
    logic                       stim_clk;
    logic                       stim_sw;

    logic [rke_pkg::EVENT_W-1:0] got_event;
    rke_pkg::event_t             want_event;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic rke_pkg::event_t classify_poll(input rke_pkg::poll_t p);
        logic [rke_pkg::TIME_W-1:0] held;
        logic [rke_pkg::TIME_W-1:0] since_click;
        if (p.clk_level != knob_prev_clk && p.clk_level == rke_pkg::LEVEL_LOW) begin
            knob_prev_clk = p.clk_level;
            return (p.data_level != p.clk_level) ? rke_pkg::EV_RIGHT : rke_pkg::EV_LEFT;
        end
        knob_prev_clk = p.clk_level;
        if (p.switch_level == rke_pkg::LEVEL_LOW && !btn_held) begin
            btn_held  = 1'b1;
            btn_start = p.now_ms;
        end
        if (p.switch_level != rke_pkg::LEVEL_LOW && btn_held) begin
            held = p.now_ms - btn_start;
            btn_held = 1'b0;
            if (held >= cfg_long) begin
                click_pending = 1'b0;
                return rke_pkg::EV_LONG;
            end
            if (!p.allow_double) begin
                click_pending = 1'b0;
                return rke_pkg::EV_SHORT;
            end
            since_click = p.now_ms - click_time;
            if (click_pending && since_click <= cfg_double) begin
                click_pending = 1'b0;
                return rke_pkg::EV_DOUBLE;
            end
            click_pending = 1'b1;
            click_time    = p.now_ms;
        end
        since_click = p.now_ms - click_time;
        if (click_pending && since_click > cfg_double) begin
            click_pending = 1'b0;
            return rke_pkg::EV_SHORT;
        end
        return rke_pkg::EV_NONE;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_event = m_tdata[rke_pkg::EVENT_W-1:0];
            if (pending_events.size() == 0) begin
                $error("event_code with no request pending: expected none, actual %0d",
                       got_event);
                error_count++;
            end else begin
                want_event = pending_events.pop_front();
                if (got_event !== want_event) begin
                    $error("event_code mismatch: expected %0d, actual %0d",
                           want_event, got_event);
                    error_count++;
                end
            end
        end
    end

    // Randomly stall the result stream
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (sink_stall_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic apb_xfer(input bit wr, input rke_pkg::reg_index_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
    endtask

    task automatic write_timing(input rke_pkg::reg_index_t idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, val, rd);
        if (idx == rke_pkg::REG_LONG_PRESS) cfg_long = val;
        else cfg_double = val;
        apb_xfer(1'b0, idx, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (rd !== val) begin
            $error("%s mismatch: expected %0d, actual %0d",
                   (idx == rke_pkg::REG_LONG_PRESS) ? "long_press_ms" : "double_click_ms",
                   val, rd);
            error_count++;
        end
    endtask

    task automatic send_poll(input rke_pkg::poll_t p);
        s_tdata  <= rke_pkg::IN_TDATA_W'(p);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_events.push_back(classify_poll(p));
        poll_count++;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic poll_at(input logic clk_l, input logic data_l, input logic sw_l,
                           input logic [rke_pkg::TIME_W-1:0] now, input logic allow);
        rke_pkg::poll_t p;
        p.clk_level    = clk_l;
        p.data_level   = data_l;
        p.switch_level = sw_l;
        p.now_ms       = now;
        p.allow_double = allow;
        send_poll(p);
        stim_clk = clk_l;
        stim_sw  = sw_l;
        stim_ms  = now;
    endtask

    task automatic send_noise();
        rke_pkg::poll_t p;
        p.clk_level    = 1'($urandom_range(0, 1));
        p.data_level   = 1'($urandom_range(0, 1));
        p.switch_level = 1'($urandom_range(0, 1));
        p.now_ms       = $urandom;
        p.allow_double = 1'($urandom_range(0, 1));
        send_poll(p);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [rke_pkg::TIME_W-1:0] span_near(
        input logic [rke_pkg::TIME_W-1:0] thr);
        case ($urandom_range(0, 6))
            0: return thr - 1;
            1: return thr;
            2: return thr + 1;
            3, 4: return $urandom_range(0, 60);
            5: return $urandom_range(0, thr);
            default: return $urandom;
        endcase
    endfunction

    // Knob gestures with random content: turns, clicks and waits
    task automatic play_knob(input int target, input int noise_pct);
        logic [rke_pkg::TIME_W-1:0] press_ms;
        logic                       allow;
        while (poll_count < target) begin
            allow = ($urandom_range(0, 99) < 85);
            if ($urandom_range(0, 99) < noise_pct) begin
                send_noise();
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        poll_at(rke_pkg::LEVEL_HIGH, 1'($urandom_range(0, 1)), stim_sw,
                                stim_ms + $urandom_range(0, 20), allow);
                        poll_at(rke_pkg::LEVEL_LOW, 1'($urandom_range(0, 1)), stim_sw,
                                stim_ms + $urandom_range(0, 20), allow);
                    end
                    1, 2: begin
                        press_ms = stim_ms + $urandom_range(0, 40);
                        poll_at(stim_clk, 1'($urandom_range(0, 1)), rke_pkg::LEVEL_LOW,
                                press_ms, allow);
                        repeat ($urandom_range(0, 2))
                            poll_at(stim_clk, 1'($urandom_range(0, 1)), rke_pkg::LEVEL_LOW,
                                    stim_ms + $urandom_range(0, 30), allow);
                        if (stim_clk == rke_pkg::LEVEL_HIGH && $urandom_range(0, 5) == 0)
                            poll_at(rke_pkg::LEVEL_LOW, 1'($urandom_range(0, 1)),
                                    rke_pkg::LEVEL_HIGH, stim_ms + $urandom_range(0, 10),
                                    allow);
                        poll_at(stim_clk, 1'($urandom_range(0, 1)), rke_pkg::LEVEL_HIGH,
                                press_ms + span_near(cfg_long), allow);
                    end
                    default: begin
                        poll_at(stim_clk, 1'($urandom_range(0, 1)), stim_sw,
                                stim_ms + span_near(cfg_double), allow);
                    end
                endcase
            end
        end
    endtask

    task automatic test_directed();
        poll_at(1'b1, 1'b0, 1'b1, 32'd0, 1'b1);
        poll_at(1'b0, 1'b1, 1'b1, 32'd5, 1'b1);
        poll_at(1'b1, 1'b0, 1'b1, 32'd6, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd7, 1'b1);
        // short press with double press disabled
        poll_at(1'b0, 1'b1, 1'b0, 32'd100, 1'b0);
        poll_at(1'b0, 1'b0, 1'b1, 32'd200, 1'b0);
        // hold exactly at the long press threshold
        poll_at(1'b0, 1'b0, 1'b0, 32'd1000, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd1800, 1'b1);
        // one below threshold, then window edge and expiry
        poll_at(1'b0, 1'b0, 1'b0, 32'd2000, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd2799, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd3099, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd3100, 1'b1);
        // double press right at the window edge
        poll_at(1'b0, 1'b0, 1'b0, 32'd4000, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd4050, 1'b1);
        poll_at(1'b0, 1'b0, 1'b0, 32'd4300, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd4350, 1'b1);
        // switch is ignored while a rotation is reported
        poll_at(1'b1, 1'b1, 1'b1, 32'd5000, 1'b1);
        poll_at(1'b0, 1'b1, 1'b0, 32'd5010, 1'b1);
        poll_at(1'b0, 1'b1, 1'b0, 32'd5020, 1'b1);
        poll_at(1'b1, 1'b1, 1'b1, 32'd5030, 1'b1);
        // pending click survives a rotation poll
        poll_at(1'b0, 1'b0, 1'b1, 32'd6000, 1'b1);
        poll_at(1'b0, 1'b0, 1'b1, 32'd6001, 1'b1);
        // hold across the timestamp wrap
        poll_at(1'b0, 1'b1, 1'b0, 32'hFFFF_FF80, 1'b1);
        poll_at(1'b0, 1'b1, 1'b1, 32'h0000_0010, 1'b0);
        poll_at(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        hold_until_drained();
    endtask

    task automatic test_default_timing();
        play_knob(poll_count + 250, 15);
        hold_until_drained();
    endtask

    task automatic test_zero_windows();
        write_timing(rke_pkg::REG_LONG_PRESS, 32'd0);
        write_timing(rke_pkg::REG_DOUBLE_CLICK, 32'd0);
        play_knob(poll_count + 150, 15);
        hold_until_drained();
    endtask

    task automatic test_max_windows();
        write_timing(rke_pkg::REG_LONG_PRESS, 32'hFFFF_FFFF);
        write_timing(rke_pkg::REG_DOUBLE_CLICK, 32'hFFFF_FFFF);
        play_knob(poll_count + 150, 15);
        hold_until_drained();
    endtask

    task automatic test_random_windows();
        repeat (3) begin
            write_timing(rke_pkg::REG_LONG_PRESS, $urandom_range(1, 2000));
            write_timing(rke_pkg::REG_DOUBLE_CLICK, $urandom_range(0, 1000));
            play_knob(poll_count + 75, 15);
            // pause the sender until every request has its event
            hold_until_drained();
            play_knob(poll_count + 75, 15);
            hold_until_drained();
        end
    endtask

    task automatic test_noise();
        write_timing(rke_pkg::REG_LONG_PRESS, $urandom);
        write_timing(rke_pkg::REG_DOUBLE_CLICK, $urandom);
        play_knob(poll_count + 150, 100);
        hold_until_drained();
    endtask

    task automatic test_back_to_back();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        write_timing(rke_pkg::REG_LONG_PRESS, rke_pkg::LONG_PRESS_RESET);
        write_timing(rke_pkg::REG_DOUBLE_CLICK, rke_pkg::DOUBLE_CLICK_RESET);
        play_knob(poll_count + 200, 15);
        hold_until_drained();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cfg_long      = rke_pkg::LONG_PRESS_RESET;
        cfg_double    = rke_pkg::DOUBLE_CLICK_RESET;
        knob_prev_clk = rke_pkg::LEVEL_HIGH;
        btn_held      = 1'b0;
        btn_start     = '0;
        click_pending = 1'b0;
        click_time    = '0;
        error_count   = 0;
        poll_count    = 0;
        stim_ms       = '0;
        stim_clk      = rke_pkg::LEVEL_HIGH;
        stim_sw       = rke_pkg::LEVEL_HIGH;
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_default_timing();
        test_zero_windows();
        test_max_windows();
        test_random_windows();
        test_noise();
        test_back_to_back();

        s_tvalid <= 1'b0;
        for (int i = 0; i < 2000 && pending_events.size() != 0; i++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_events.size() != 0) begin
            $error("event_code missing: expected %0d more events, actual none",
                   pending_events.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> rotary_knob_event_decoder.f
rtl/core/rke_pkg.sv
rtl/core/rke_cfg_regs.sv
rtl/core/rke_in_stage.sv
rtl/core/rke_classifier.sv
rtl/core/rotary_knob_event_decoder.sv
rtl/core/rke_checker.sv
dv/tb_rotary_knob_event_decoder.sv
